### hdl/transparent_rle_row_encoder_defines.svh
// Assertion macros used by the checker file of the row encoder.
// No dependencies.
`ifndef TRANSPARENT_RLE_ROW_ENCODER_DEFINES_SVH
`define TRANSPARENT_RLE_ROW_ENCODER_DEFINES_SVH

// Checked at every edge, reset included.
`define TRLE_ASSERT(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Checked only outside reset.
`define TRLE_ASSERT_NR(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

### hdl/trle_pkg.sv
// Shared types and constants of the transparent RLE row encoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package trle_pkg;

  localparam int CMD_FIFO_DEPTH = 4;

  typedef enum logic {
    RUN_TRANS,
    RUN_SOLID
  } run_kind_t;

  typedef struct packed {
    run_kind_t  kind;
    logic [7:0] count;
    logic       last;
  } run_cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_LIT
  } bk_state_t;

endpackage

`default_nettype wire

### hdl/trle_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module trle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hdl/trle_cmd_fifo.sv
// Short run command queue between the front and back parts of the encoder.
// Depends on trle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trle_cmd_fifo
  import trle_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  run_cmd_t din,
  output logic     full,
  input  logic     pop,
  output logic     empty,
  output run_cmd_t head
);

  localparam int PW = $clog2(CMD_FIFO_DEPTH);

  run_cmd_t        slots [CMD_FIFO_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     fill;
  logic            do_push;
  logic            do_pop;

  assign full    = (fill == (PW+1)'(CMD_FIFO_DEPTH));
  assign empty   = (fill == '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/trle_front.sv
// Front part: takes pixels, tracks runs and column, fills the literal
// buffer and issues run flush commands. Depends on trle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trle_front
  import trle_pkg::*;
#(
  parameter int ROW_WIDTH = 32,
  parameter int AW        = (ROW_WIDTH > 1) ? $clog2(ROW_WIDTH) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [7:0]    pixel,
  output logic          full,
  output logic          q_push,
  output run_cmd_t      q_din,
  input  logic          q_full,
  input  logic          solid_done,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data
);

  localparam int CW = $clog2(ROW_WIDTH + 1);

  logic [CW-1:0] tcount, tcount_next;
  logic [CW-1:0] scount, scount_next;
  logic [CW-1:0] column, column_next;
  logic          solid_busy;
  logic          pend_valid;
  run_cmd_t      pend;
  logic          accept;
  logic          row_end;
  logic          a_valid, b_valid;
  run_cmd_t      cmd_a, cmd_b;
  logic          busy_set;

  assign full    = pend_valid || q_full || solid_busy;
  assign accept  = push && !full;
  assign row_end = (column == CW'(ROW_WIDTH - 1));
  assign wr_addr = AW'(scount);
  assign wr_data = pixel;

  always_comb begin
    a_valid     = 1'b0;
    b_valid     = 1'b0;
    cmd_a       = '0;
    cmd_b       = '0;
    tcount_next = tcount;
    scount_next = scount;
    column_next = column;
    wr_en       = 1'b0;
    busy_set    = 1'b0;
    if (accept) begin
      column_next = column + 1'b1;
      if (pixel != 8'd0) begin
        if (tcount != '0) begin
          a_valid    = 1'b1;
          cmd_a.kind  = RUN_TRANS;
          cmd_a.count = 8'(tcount);
        end
        tcount_next = '0;
        scount_next = scount + 1'b1;
        wr_en       = 1'b1;
      end else begin
        if (scount != '0) begin
          a_valid     = 1'b1;
          cmd_a.kind  = RUN_SOLID;
          cmd_a.count = 8'(scount);
          busy_set    = 1'b1;
        end
        scount_next = '0;
        tcount_next = tcount + 1'b1;
      end
      if (row_end) begin
        b_valid = 1'b1;
        cmd_b.last = 1'b1;
        if (pixel != 8'd0) begin
          cmd_b.kind  = RUN_SOLID;
          cmd_b.count = 8'(scount_next);
          busy_set    = 1'b1;
        end else begin
          cmd_b.kind  = RUN_TRANS;
          cmd_b.count = 8'(tcount_next);
        end
        tcount_next = '0;
        scount_next = '0;
        column_next = '0;
      end else begin
        cmd_a.last = 1'b1;
      end
    end
  end

  always_comb begin
    q_push = 1'b0;
    q_din  = cmd_b;
    if (pend_valid) begin
      q_push = !q_full;
      q_din  = pend;
    end else if (accept && a_valid) begin
      q_push = 1'b1;
      q_din  = cmd_a;
    end else if (accept && b_valid) begin
      q_push = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && a_valid && b_valid) begin
      pend <= cmd_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tcount     <= '0;
      scount     <= '0;
      column     <= '0;
      solid_busy <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      tcount <= tcount_next;
      scount <= scount_next;
      column <= column_next;
      if (busy_set) begin
        solid_busy <= 1'b1;
      end else if (solid_done) begin
        solid_busy <= 1'b0;
      end
      if (accept && a_valid && b_valid) begin
        pend_valid <= 1'b1;
      end else if (pend_valid && !q_full) begin
        pend_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/trle_back.sv
// Back part: executes run commands, emitting count bytes and buffered
// literals into the output register. Depends on trle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trle_back
  import trle_pkg::*;
#(
  parameter int ROW_WIDTH = 32,
  parameter int AW        = (ROW_WIDTH > 1) ? $clog2(ROW_WIDTH) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  run_cmd_t      q_head,
  output logic          q_pop,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  input  logic [7:0]    rd_data,
  output logic          solid_done,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    out_byte,
  output logic          last
);

  bk_state_t     state, state_next;
  run_cmd_t      cmd, cmd_next;
  logic [AW-1:0] idx, idx_next;
  logic          out_valid;
  logic          slot_free;
  logic          out_load;
  logic [7:0]    byte_next;
  logic          last_next;
  logic          lit_final;

  assign empty     = !out_valid;
  assign slot_free = !out_valid || pop;
  assign lit_final = ((8'(idx) + 8'd1) == cmd.count);

  always_comb begin
    state_next = state;
    cmd_next   = cmd;
    idx_next   = idx;
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = idx;
    solid_done = 1'b0;
    out_load   = 1'b0;
    byte_next  = rd_data;
    last_next  = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty && slot_free) begin
          q_pop    = 1'b1;
          out_load = 1'b1;
          if (q_head.kind == RUN_SOLID) begin
            byte_next  = q_head.count;
            rd_en      = 1'b1;
            rd_addr    = '0;
            idx_next   = '0;
            cmd_next   = q_head;
            state_next = BK_LIT;
          end else begin
            byte_next = 8'd0 - q_head.count;
            last_next = q_head.last;
          end
        end
      end
      BK_LIT: begin
        if (slot_free) begin
          out_load  = 1'b1;
          last_next = cmd.last && lit_final;
          if (lit_final) begin
            solid_done = 1'b1;
            state_next = BK_IDLE;
          end else begin
            idx_next = idx + 1'b1;
            rd_en    = 1'b1;
            rd_addr  = idx + 1'b1;
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    cmd <= cmd_next;
    idx <= idx_next;
    if (out_load) begin
      out_byte <= byte_next;
      last     <= last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/transparent_rle_row_encoder.sv
// Transparent run-length row encoder, top level.
// Depends on trle_pkg, trle_front, trle_cmd_fifo, trle_back, trle_ram.
//
// Usage: pixels go in through a queue-style port (push/full, taken when push
// is high and full low). Encoded bytes come out the same way (empty/pop): the
// oldest byte sits on out_byte/last while empty is low and leaves when pop is
// high. A row is ROW_WIDTH pixels, counted inside. A transparent run leaves as
// one negated count byte, a solid run as its count byte and then its pixels;
// last marks the final byte caused by one pixel.
// A run byte passes through the command queue and then the output register.
// Throughput: one pixel per cycle while only run state changes and full is
// low; output is one byte per cycle while pop is high and bytes are pending.
// A solid run of N pixels gives N+1 output bytes (count byte, then literals);
// full stays high from the pixel that ends it until its last literal is loaded.
// The command queue holds four run commands; full also rises when it fills, and
// after a row-end pixel that ends a run, until its second command is queued.
// Reset clears run counts, column, queue and output valid flag; no clearing
// pass is needed, so the block takes pixels in the first cycle after reset.
// A stalled output (pop low) holds its byte and backs up into the queue
// and then onto full.
`timescale 1ns / 1ps
`default_nettype none

module transparent_rle_row_encoder
  import trle_pkg::*;
#(
  parameter int ROW_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] pixel,
  output logic       full,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       last
);

  localparam int AW = (ROW_WIDTH > 1) ? $clog2(ROW_WIDTH) : 1;

  logic          q_push, q_full, q_pop, q_empty;
  run_cmd_t      q_din, q_head;
  logic          solid_done;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;

  trle_front #(.ROW_WIDTH(ROW_WIDTH), .AW(AW)) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pixel      (pixel),
    .full       (full),
    .q_push     (q_push),
    .q_din      (q_din),
    .q_full     (q_full),
    .solid_done (solid_done),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  trle_cmd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .head  (q_head)
  );

  trle_ram #(.WIDTH(8), .DEPTH(ROW_WIDTH), .AW(AW)) u_lit_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  trle_back #(.ROW_WIDTH(ROW_WIDTH), .AW(AW)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .solid_done (solid_done),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .last       (last)
  );

endmodule

`default_nettype wire

### hdl/trle_checker.sv
// Port-level checks of the transparent RLE row encoder, bound to the top.
// Depends on transparent_rle_row_encoder_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "transparent_rle_row_encoder_defines.svh"

module trle_checker (
  input wire       clk,
  input wire       rst,
  input wire       full,
  input wire       empty,
  input wire       pop,
  input wire [7:0] out_byte,
  input wire       last
);

  `TRLE_ASSERT(a_reset_idle, clk, rst |=> (empty && !full), "not idle after reset")
  `TRLE_ASSERT_NR(a_nonzero_byte, clk, rst, !empty |-> (out_byte != 8'd0), "zero byte emitted")
  `TRLE_ASSERT_NR(a_stall_hold, clk, rst, (!empty && !pop) |=> (!empty && $stable({out_byte, last})), "stalled transaction changed")

endmodule

bind transparent_rle_row_encoder trle_checker u_trle_checker (
  .clk      (clk),
  .rst      (rst),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_byte (out_byte),
  .last     (last)
);

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for transparent_rle_row_encoder: a short table of directed
// pixels, then random rows; bytes checked against the table or an in-bench encoder.
// Depends on the encoder RTL only.
`timescale 1ns / 1ps

module testbench;

  localparam int ROW_WIDTH   = 32;
  localparam int ITEMS       = 430;
  localparam int GAP_MAX     = 12;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN       = 40;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DIR_LEN     = 24;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } enc_byte_t;

  typedef struct packed {
    logic       typed;
    logic [1:0] n;
    logic [7:0] px;
    logic [7:0] b0;
    logic [7:0] b1;
  } dir_row_t;

  typedef enum logic [2:0] {
    ROW_RUNS,
    ROW_SOLID,
    ROW_CLEAR,
    ROW_SOLID_END_CLEAR,
    ROW_CLEAR_END_SOLID,
    ROW_NOISE
  } row_mode_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic [7:0] pixel = 8'h00;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic       last;

  // encoder state
  logic [5:0] trans_run = '0;
  logic [5:0] solid_run = '0;
  logic [5:0] column = '0;
  logic [7:0] literal_buf [ROW_WIDTH];

  enc_byte_t  byte_q[$];
  enc_byte_t  step_bytes[$];
  dir_row_t   dir_tab [DIR_LEN];

  row_mode_t  row_mode = ROW_RUNS;
  int         run_left = 0;
  logic       run_solid = 1'b0;
  logic       send_burst = 1'b0;
  logic       recv_burst = 1'b0;
  logic       hold_off = 1'b0;

  int n_sent = 0;
  int n_popped = 0;
  int n_errors = 0;
  int max_step = 0;
  int n_mode [6] = '{default: 0};
  int cycles = 0;

  transparent_rle_row_encoder #(
    .ROW_WIDTH(ROW_WIDTH)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .pixel   (pixel),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .out_byte(out_byte),
    .last    (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d bytes still pending", cycles, byte_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    n_errors++;
    if (n_errors <= 50)
      $display("%0t: ERROR %s: got %h, expected %h", $time, what, got, want);
  endtask

  function automatic void emit(input logic [7:0] v, input logic l);
    enc_byte_t e;
    e.value = v;
    e.last  = l;
    step_bytes.push_back(e);
  endfunction

  function automatic void flush_clear();
    if (trans_run != 0) begin
      emit(8'd0 - {2'b00, trans_run}, 1'b0);
      trans_run = '0;
    end
  endfunction

  function automatic void flush_solid();
    if (solid_run != 0) begin
      emit({2'b00, solid_run}, 1'b0);
      for (int i = 0; i < solid_run; i++)
        emit(literal_buf[i], 1'b0);
      solid_run = '0;
    end
  endfunction

  function automatic void encode_pixel(input logic [7:0] px);
    enc_byte_t tail;
    step_bytes.delete();
    if (px != 8'h00) begin
      flush_clear();
      if (solid_run < ROW_WIDTH) begin
        literal_buf[solid_run] = px;
        solid_run++;
      end
    end else begin
      flush_solid();
      if (trans_run < ROW_WIDTH)
        trans_run++;
    end
    column++;
    if (column >= ROW_WIDTH) begin
      flush_clear();
      flush_solid();
      column = '0;
    end
    if (step_bytes.size() > 0) begin
      tail = step_bytes.pop_back();
      tail.last = 1'b1;
      step_bytes.push_back(tail);
    end
  endfunction

  function automatic logic [7:0] solid_px();
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic void pick_row_mode();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      5: row_mode = ROW_SOLID;
      6: row_mode = ROW_CLEAR;
      7: row_mode = ROW_SOLID_END_CLEAR;
      8: row_mode = ROW_CLEAR_END_SOLID;
      9: row_mode = ROW_NOISE;
      default: row_mode = ROW_RUNS;
    endcase
    n_mode[row_mode]++;
  endfunction

  function automatic logic [7:0] next_pixel();
    logic row_end;
    row_end = (column == ROW_WIDTH - 1);
    case (row_mode)
      ROW_SOLID:           return solid_px();
      ROW_CLEAR:           return 8'h00;
      ROW_SOLID_END_CLEAR: return row_end ? 8'h00 : solid_px();
      ROW_CLEAR_END_SOLID: return row_end ? solid_px() : 8'h00;
      ROW_NOISE:           return $urandom_range(0, 1) ? solid_px() : 8'h00;
      default: begin
        if (run_left == 0) begin
          run_solid = !run_solid;
          run_left  = $urandom_range(1, 8);
        end
        run_left--;
        return run_solid ? solid_px() : 8'h00;
      end
    endcase
  endfunction

  task automatic drive_pixel(input logic [7:0] px);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, GAP_MAX);
    if ($urandom_range(0, 39) == 0)
      send_burst = !send_burst;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push  <= 1'b1;
    pixel <= px;
    do @(posedge clk); while (full);
    n_sent++;
    encode_pixel(px);
    if (step_bytes.size() > max_step)
      max_step = step_bytes.size();
  endtask

  // pixel source
  initial begin
    dir_row_t r;
    dir_tab = '{
      '{1'b1, 2'd0, 8'h05, 8'h00, 8'h00},
      '{1'b1, 2'd2, 8'h00, 8'h01, 8'h05},
      '{1'b1, 2'd1, 8'hFF, 8'hFF, 8'h00},
      '{1'b1, 2'd0, 8'h80, 8'h00, 8'h00},
      '{1'b1, 2'd0, 8'h01, 8'h00, 8'h00},
      '{1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
      '{1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
      '{1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
      '{1'b1, 2'd1, 8'hAA, 8'hFD, 8'h00},
      '{1'b1, 2'd0, 8'h55, 8'h00, 8'h00},
      '{1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
      '{1'b1, 2'd1, 8'h7F, 8'hFF, 8'h00},
      '{1'b1, 2'd2, 8'h00, 8'h01, 8'h7F},
      '{1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
      '{1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
      '{1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
      '{1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
      '{1'b1, 2'd1, 8'h01, 8'hFB, 8'h00},
      '{1'b1, 2'd0, 8'hFE, 8'h00, 8'h00},
      '{1'b1, 2'd0, 8'hFD, 8'h00, 8'h00},
      '{1'b1, 2'd0, 8'hFB, 8'h00, 8'h00},
      '{1'b1, 2'd0, 8'hF7, 8'h00, 8'h00},
      '{1'b1, 2'd0, 8'hEF, 8'h00, 8'h00},
      '{1'b1, 2'd0, 8'hDF, 8'h00, 8'h00}
    };
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_LEN; i++) begin
      r = dir_tab[i];
      drive_pixel(r.px);
      if (!r.typed) begin
        foreach (step_bytes[k]) byte_q.push_back(step_bytes[k]);
      end else if (r.n == 2'd1) begin
        byte_q.push_back({r.b0, 1'b1});
      end else if (r.n == 2'd2) begin
        byte_q.push_back({r.b0, 1'b0});
        byte_q.push_back({r.b1, 1'b1});
      end
    end

    while (n_sent < ITEMS || column != 0) begin
      if (column == 0)
        pick_row_mode();
      drive_pixel(next_pixel());
      foreach (step_bytes[k]) byte_q.push_back(step_bytes[k]);
    end
    push <= 1'b0;

    while (byte_q.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Encoded %0d pixels in %0d rows into %0d bytes; up to %0d bytes from one pixel",
             n_sent, n_sent / ROW_WIDTH, n_popped, max_step);
    $display("Random rows: %0d mixed runs, %0d solid, %0d clear, %0d+%0d end switch, %0d noise",
             n_mode[ROW_RUNS], n_mode[ROW_SOLID], n_mode[ROW_CLEAR],
             n_mode[ROW_SOLID_END_CLEAR], n_mode[ROW_CLEAR_END_SOLID], n_mode[ROW_NOISE]);
    if (n_errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // byte sink and checker
  initial begin
    int gap;
    enc_byte_t want;
    wait (!rst);
    forever begin
      gap = recv_burst ? 0 : $urandom_range(0, GAP_MAX);
      if ($urandom_range(0, 39) == 0)
        recv_burst = !recv_burst;
      if (gap > 0 || hold_off) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      n_popped++;
      if (byte_q.size() == 0) begin
        report("transaction with nothing expected", out_byte, 8'h00);
      end else begin
        want = byte_q.pop_front();
        if (out_byte !== want.value)
          report("out_byte", out_byte, want.value);
        if (last !== want.last)
          report("last", {7'd0, last}, {7'd0, want.last});
      end
    end
  end

  // long output stall so the input side backs up
  initial begin
    wait (n_popped >= 40);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

endmodule

### transparent_rle_row_encoder.f
+incdir+hdl
hdl/trle_pkg.sv
hdl/trle_ram.sv
hdl/trle_cmd_fifo.sv
hdl/trle_front.sv
hdl/trle_back.sv
hdl/transparent_rle_row_encoder.sv
hdl/trle_checker.sv
sim/testbench.sv
